@@ sv/pfrgba_pkg.sv @@
package pfrgba_pkg;

  // Largest accepted frame side; bigger register values saturate to it.
  localparam int unsigned MaxSide = 4096;

  // Frame size and pixel counter widths.
  localparam int unsigned FrameW = $clog2(MaxSide * MaxSide + 1);
  localparam int unsigned CountW = 24;

  // Configuration register widths.
  localparam int unsigned FmtW  = 3;
  localparam int unsigned SideW = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  // Source pixel formats.
  typedef enum logic [FmtW-1:0] {
    FmtRgb888   = 3'd0,
    FmtRgba8888 = 3'd1,
    FmtRgb565   = 3'd2,
    FmtRgb565A  = 3'd3,
    FmtAlpha8   = 3'd4
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgFormat = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_idx_e;

  // One expanded pixel, red in the lowest byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Fill status of the pixel queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] Opaque = 8'd255;
  localparam logic [4:0] Mask5 = 5'h1F;
  localparam logic [5:0] Mask6 = 6'h3F;

  // Zero counts as one; values above the limit saturate.
  function automatic logic [SideW-1:0] side_of(logic [SideW-1:0] v);
    logic [SideW-1:0] s;
    if (v == '0) begin
      s = SideW'(1);
    end else if (v > SideW'(MaxSide)) begin
      s = SideW'(MaxSide);
    end else begin
      s = v;
    end
    return s;
  endfunction

  // Widen a 5-bit channel by replicating its top bits.
  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [4:0] m;
    m = v & Mask5;
    return {m, m[4:2]};
  endfunction

  // Widen a 6-bit channel by replicating its top bits.
  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [5:0] m;
    m = v & Mask6;
    return {m, m[5:4]};
  endfunction

endpackage

@@ sv/pixel_format_to_rgba8888_unit.sv @@
// A pixel's final byte is written into the pixel queue, and the pixel then moves into the
// output register that drives the master side.
// Throughput: one byte per cycle while the queue has room for completed pixels; a two-entry pixel queue between the
// byte assembler and the output register lets either side stall on its own.
// Reset (asynchronous, active low): format RGB888, width and height one, no bytes held,
// pixel counter zero, queue and output empty.
module pixel_format_to_rgba8888_unit
  import pfrgba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // data_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,   // red, green, blue, alpha
  output logic                m_axis_tlast_o,   // last_pixel
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [FmtW-1:0]  format_q;
  logic [SideW-1:0] width_q, height_q;
  logic             push, pop;
  pixel_t           push_data, q_data, out_pixel;
  q_stat_t          q_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FmtRgb888;
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFormat: format_q <= cfg_data_i[FmtW-1:0];
        CfgWidth:  width_q  <= cfg_data_i[SideW-1:0];
        CfgHeight: height_q <= cfg_data_i[SideW-1:0];
        default:   format_q <= format_q;
      endcase
    end
  end

  pfrgba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .format_i    (format_q),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pfrgba_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .stat_o      (q_stat)
  );

  pfrgba_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .q_stat_i   (q_stat),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_pixel_o  (out_pixel),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_pixel;

  // A pixel is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("pixel pushed into full queue");

  // A queued pixel reaches an empty output register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !m_axis_tvalid_o) |=> m_axis_tvalid_o)
    else $error("queued pixel not moved to output");

  // The queue cannot be full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

@@ sv/pfrgba_front.sv @@
module pfrgba_front
  import pfrgba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [FmtW-1:0]  format_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [7:0]       s_tdata_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output pixel_t           push_data_o
);

  logic [1:0]      phase_q, phase_d;
  logic [2:0][7:0] held_q, held_d;
  logic [2:0]      need;
  logic            fmt_ok;
  logic            complete;
  logic            accept;
  logic [15:0]     word;

  // Byte count of one source pixel; zero for codes without a format.
  always_comb begin
    unique case (format_i)
      FmtRgb888:   need = 3'd3;
      FmtRgba8888: need = 3'd4;
      FmtRgb565:   need = 3'd2;
      FmtRgb565A:  need = 3'd3;
      FmtAlpha8:   need = 3'd1;
      default:     need = 3'd0;
    endcase
  end

  // Completion depends on phase and format only, never on the data.
  assign fmt_ok   = (need != 3'd0);
  assign complete = fmt_ok && ((3'({1'b0, phase_q}) + 3'd1) >= need);

  // Bytes that only get held are always taken; a completing byte needs queue room.
  assign s_tready_o = !complete || !q_stat_i.full;
  assign accept     = s_tvalid_i && s_tready_o;
  assign push_o     = accept && complete;

  // Assemble the pixel from the held bytes and the final byte.
  always_comb begin
    push_data_o = '{alpha: Opaque, blue: Opaque, green: Opaque, red: Opaque};
    word        = {s_tdata_i, held_q[0]};
    unique case (format_i)
      FmtRgb888: begin
        push_data_o.red   = held_q[0];
        push_data_o.green = held_q[1];
        push_data_o.blue  = s_tdata_i;
      end
      FmtRgba8888: begin
        push_data_o.red   = held_q[0];
        push_data_o.green = held_q[1];
        push_data_o.blue  = held_q[2];
        push_data_o.alpha = s_tdata_i;
      end
      FmtRgb565: begin
        push_data_o.red   = widen5(word[15:11]);
        push_data_o.green = widen6(word[10:5]);
        push_data_o.blue  = widen5(word[4:0]);
      end
      FmtRgb565A: begin
        word              = {held_q[1], held_q[0]};
        push_data_o.red   = widen5(word[15:11]);
        push_data_o.green = widen6(word[10:5]);
        push_data_o.blue  = widen5(word[4:0]);
        push_data_o.alpha = s_tdata_i;
      end
      default: begin
        push_data_o.alpha = s_tdata_i;
      end
    endcase
  end

  // Byte phase and held bytes.
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept && fmt_ok) begin
      if (complete) begin
        phase_d = 2'd0;
        held_d  = '0;
      end else begin
        phase_d = phase_q + 2'd1;
        case (phase_q)
          2'd0:    held_d[0] = s_tdata_i;
          2'd1:    held_d[1] = s_tdata_i;
          2'd2:    held_d[2] = s_tdata_i;
          default: held_d    = held_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

@@ sv/pfrgba_queue.sv @@
module pfrgba_queue
  import pfrgba_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pixel_t  push_data_i,
  input  logic    pop_i,
  output pixel_t  pop_data_o,
  output q_stat_t stat_o
);

  localparam logic [1:0] Depth = 2'd2;

  pixel_t     mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;

  assign stat_o.full  = (count_q == Depth);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/pfrgba_back.sv @@
module pfrgba_back
  import pfrgba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SideW-1:0] width_i,
  input  logic [SideW-1:0] height_i,
  input  q_stat_t          q_stat_i,
  input  pixel_t           q_data_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output pixel_t           m_pixel_o,
  output logic             m_last_o
);

  logic [FrameW-1:0]   frame_q;
  logic [2*SideW-1:0]  frame_prod;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW:0]     count_inc;
  logic                is_last;
  logic                valid_q, valid_d;
  pixel_t              pixel_q;
  logic                last_q;

  // Frame size, registered in the cycle after the side registers.
  assign frame_prod = (2*SideW)'(side_of(width_i)) * (2*SideW)'(side_of(height_i));

  // Take the next pixel whenever the output register is free or drains.
  assign pop_o     = !q_stat_i.empty && (!valid_q || m_tready_i);
  assign count_inc = {1'b0, count_q} + (CountW+1)'(1);
  assign is_last   = ((FrameW > CountW + 1) ? FrameW'(count_inc) : count_inc[FrameW-1:0])
                     >= frame_q;

  // Pixel counter and output valid.
  always_comb begin
    count_d = count_q;
    valid_d = valid_q;
    if (pop_o) begin
      count_d = is_last ? '0 : count_inc[CountW-1:0];
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameW'(1);
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      frame_q <= frame_prod[FrameW-1:0];
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q <= q_data_i;
      last_q  <= is_last;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_pixel_o  = pixel_q;
  assign m_last_o   = last_q;

endmodule

@@ tb/rgba_pixel_checker.sv @@
`timescale 1ns / 1ps

// Watches the byte input, the pixel output and the register port of the unpacker.
// Keeps its own copy of the format, frame size, held bytes and pixel counter,
// predicts one pixel per completed source pixel, and checks results in order.
module rgba_pixel_checker
  import pfrgba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [7:0]          s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [31:0]         m_data_i,   // red, green, blue, alpha
  input  logic                m_last_i,   // last_pixel
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  pixels_o,
  output int                  frames_o
);

  typedef struct packed {
    pixel_t px;
    logic   last;
  } rgba_result_t;

  // Shadow copy of the registers and of the assembly state.
  logic [FmtW-1:0]   shadow_fmt;
  logic [SideW-1:0]  shadow_width;
  logic [SideW-1:0]  shadow_height;
  logic [1:0]        byte_count;
  logic [23:0]       held;
  logic [CountW-1:0] frame_pos;

  rgba_result_t expected_pixels[$];

  // Source bytes per pixel; zero marks an unused format code.
  function automatic int bytes_per_pixel(logic [FmtW-1:0] f);
    case (f)
      FmtRgb888:   return 3;
      FmtRgba8888: return 4;
      FmtRgb565:   return 2;
      FmtRgb565A:  return 3;
      FmtAlpha8:   return 1;
      default:     return 0;
    endcase
  endfunction

  // A side of zero counts as one, oversized sides are held at the maximum.
  function automatic logic [SideW-1:0] clamp_side(logic [SideW-1:0] v);
    if (v == '0) return SideW'(1);
    if (v > SideW'(MaxSide)) return SideW'(MaxSide);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("pixel %0d: %s is 0x%02h, expected 0x%02h",
                                pixels_o, name, got, want));
    end
  endtask

  // Takes one accepted source byte; queues a pixel when it completes one.
  task automatic absorb_byte(input logic [7:0] b);
    int                need;
    logic [7:0]        p [4];
    rgba_result_t      res;
    logic [15:0]       word;
    logic [4:0]        r5;
    logic [5:0]        g6;
    logic [4:0]        b5;
    logic [FrameW-1:0] frame;
    logic [FrameW-1:0] next_pos;

    need = bytes_per_pixel(shadow_fmt);
    if (need == 0) return;

    // Not the final byte yet: hold it at its position.
    if (int'(byte_count) + 1 < need) begin
      held[byte_count*8 +: 8] = b;
      byte_count = byte_count + 2'd1;
      return;
    end

    p[0] = held[7:0];
    p[1] = held[15:8];
    p[2] = held[23:16];
    p[3] = 8'h00;
    p[need-1] = b;

    res.px = {Opaque, Opaque, Opaque, Opaque};
    case (shadow_fmt)
      FmtRgb888: begin
        res.px.red   = p[0];
        res.px.green = p[1];
        res.px.blue  = p[2];
      end
      FmtRgba8888: begin
        res.px.red   = p[0];
        res.px.green = p[1];
        res.px.blue  = p[2];
        res.px.alpha = p[3];
      end
      FmtRgb565, FmtRgb565A: begin
        word = {p[1], p[0]};
        r5 = word[15:11];
        g6 = word[10:5];
        b5 = word[4:0];
        res.px.red   = {r5, r5[4:2]};
        res.px.green = {g6, g6[5:4]};
        res.px.blue  = {b5, b5[4:2]};
        if (shadow_fmt == FmtRgb565A) res.px.alpha = p[2];
      end
      default: begin
        res.px.alpha = p[0];
      end
    endcase

    byte_count = '0;
    held = '0;

    // Frame position: a pixel that brings the count to or past the frame size flags last and wraps.
    frame = FrameW'(clamp_side(shadow_width)) * FrameW'(clamp_side(shadow_height));
    next_pos = FrameW'(frame_pos) + 1'b1;
    res.last = (next_pos >= frame);
    frame_pos = res.last ? '0 : frame_pos + 1'b1;

    expected_pixels.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgba_result_t want;
    pixel_t       got;
    if (!rst_ni) begin
      shadow_fmt = FmtRgb888;
      shadow_width = SideW'(1);
      shadow_height = SideW'(1);
      byte_count = '0;
      held = '0;
      frame_pos = '0;
      expected_pixels.delete();
      errors_o = 0;
      pending_o = 0;
      pixels_o = 0;
      frames_o = 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFormat: shadow_fmt = cfg_data_i[FmtW-1:0];
          CfgWidth:  shadow_width = cfg_data_i[SideW-1:0];
          CfgHeight: shadow_height = cfg_data_i[SideW-1:0];
          default: ;
        endcase
      end

      // Output side first, so a result can never match a pixel queued this edge.
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel 0x%08h last %0b arrived with none expected",
                                    m_data_i, m_last_i));
        end else begin
          want = expected_pixels.pop_front();
          compare_field("red", got.red, want.px.red);
          compare_field("green", got.green, want.px.green);
          compare_field("blue", got.blue, want.px.blue);
          compare_field("alpha", got.alpha, want.px.alpha);
          compare_field("last", {7'd0, m_last_i}, {7'd0, want.last});
        end
        pixels_o++;
        if (m_last_i) frames_o++;
      end

      // Input side.
      if (s_valid_i && s_ready_i) absorb_byte(s_data_i);

      pending_o = expected_pixels.size();
    end
  end

endmodule

@@ tb/pixel_format_to_rgba8888_unit_test.sv @@
`timescale 1ns / 1ps

module pixel_format_to_rgba8888_unit_test;
  import pfrgba_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int ResetCycles = 7;
  localparam int HoldCycles = 64;
  localparam int DrainPause = 4;
  localparam int EndPause = 16;
  localparam int ItemTarget = 800;

  localparam logic [FmtW-1:0] FmtUnusedLo = 3'd5;
  localparam logic [FmtW-1:0] FmtUnusedHi = 3'd7;
  localparam logic [CfgDataW-1:0] SideAllOnes = 13'h1FFF;

  typedef enum int {RxOpen, RxRandom, RxPattern} rx_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data = 8'h00;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [31:0]         m_data;
  logic                m_last;
  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_idx = CfgFormat;
  logic [CfgDataW-1:0] cfg_data = '0;

  int errors;
  int pending_pixels;
  int pixels_checked;
  int frames_closed;

  int cycles = 0;
  int bytes_used = 0;
  int bytes_dropped = 0;
  int cfg_writes = 0;
  int long_holds = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  bit long_hold_req = 1'b0;
  logic [FmtW-1:0] cur_fmt = FmtRgb888;

  always #4 clk = ~clk;

  pixel_format_to_rgba8888_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  rgba_pixel_checker checker_inst (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .m_last_i   (m_last),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending_pixels),
    .pixels_o   (pixels_checked),
    .frames_o   (frames_closed)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d pixels outstanding.",
               cycles, pending_pixels);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: switches between open, random and rotating-pattern stalls,
  // and on request holds off for a long stretch so the unpacker backs up.
  initial begin
    rx_mode_e   mode;
    int         left;
    logic [7:0] pattern;
    mode = RxOpen;
    left = 0;
    pattern = 8'b1011_0010;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_ready = 1'b0;
        long_holds++;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          left = $urandom_range(20, 200);
          pattern = 8'($urandom_range(1, 254));
        end
        left--;
        case (mode)
          RxOpen:   m_ready = 1'b1;
          RxRandom: m_ready = ($urandom_range(0, 3) != 0);
          default: begin
            pattern = {pattern[6:0], pattern[7]};
            m_ready = pattern[0];
          end
        endcase
      end
    end
  end

  function automatic int pixel_bytes(logic [FmtW-1:0] f);
    case (f)
      FmtRgb888:   return 3;
      FmtRgba8888: return 4;
      FmtRgb565:   return 2;
      FmtRgb565A:  return 3;
      FmtAlpha8:   return 1;
      default:     return 0;
    endcase
  endfunction

  // Offers one byte and waits for the request to be taken. Outside steady runs, between bursts of
  // random length the valid line usually drops for a random gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      s_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_valid = 1'b1;
    s_data = b;
    do @(posedge clk); while (!s_ready);
    if (pixel_bytes(cur_fmt) == 0) bytes_dropped++;
    else bytes_used++;
  endtask

  // Stops offering and waits until every predicted pixel has been delivered.
  task automatic go_idle();
    @(negedge clk);
    s_valid = 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (DrainPause) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
    if (idx == CfgFormat) cur_fmt = v[FmtW-1:0];
  endtask

  task automatic set_frame(input logic [FmtW-1:0] f, input logic [CfgDataW-1:0] w,
                           input logic [CfgDataW-1:0] h);
    go_idle();
    write_reg(CfgFormat, CfgDataW'(f));
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
  endtask

  // Frame sides: mostly small so frame ends are frequent, sometimes extreme.
  function automatic logic [CfgDataW-1:0] pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CfgDataW'(MaxSide);
      2:       return SideAllOnes;
      3:       return CfgDataW'($urandom_range(MaxSide + 1, 8191));
      4:       return CfgDataW'($urandom_range(0, 8191));
      default: return CfgDataW'($urandom_range(1, 5));
    endcase
  endfunction

  initial begin
    int            phase_idx;
    int            need;
    int            nbytes;
    logic [FmtW-1:0] f;

    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed: reset settings are RGB888 in a one-pixel frame.
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);

    // Zero sides count as one.
    set_frame(FmtRgba8888, '0, '0);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);

    // Oversized sides saturate; all-zero and all-one 565 words.
    set_frame(FmtRgb565, SideAllOnes, SideAllOnes);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);

    // The frame shrinks below the pixel count: the next pixel closes it.
    set_frame(FmtRgb565A, CfgDataW'(1), CfgDataW'(2));
    send_byte(8'h1F); send_byte(8'hF8); send_byte(8'h7F);

    set_frame(FmtAlpha8, CfgDataW'(MaxSide), CfgDataW'(MaxSide));
    send_byte(8'h00); send_byte(8'hFF);

    // Unused format codes swallow bytes without any effect.
    for (int u = FmtUnusedLo; u <= FmtUnusedHi; u++) begin
      go_idle();
      write_reg(CfgFormat, CfgDataW'(u));
      send_byte(8'($urandom_range(0, 255)));
    end

    // Format changes in the middle of a pixel keep the held bytes.
    go_idle();
    write_reg(CfgFormat, CfgDataW'(FmtRgba8888));
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
    go_idle();
    write_reg(CfgFormat, CfgDataW'(FmtAlpha8));
    send_byte(8'h44);
    go_idle();
    write_reg(CfgFormat, CfgDataW'(FmtRgba8888));
    send_byte(8'h55); send_byte(8'h66);
    go_idle();
    write_reg(CfgFormat, CfgDataW'(FmtRgb565));
    send_byte(8'h77);

    // Random phases: drain, reconfigure, then whole pixels of random bytes,
    // now and then with a trailing partial pixel or an unused format.
    phase_idx = 0;
    while (bytes_used < ItemTarget) begin
      if ($urandom_range(0, 11) == 0) f = FmtW'($urandom_range(FmtUnusedLo, FmtUnusedHi));
      else f = FmtW'($urandom_range(FmtRgb888, FmtAlpha8));
      go_idle();
      write_reg(CfgFormat, CfgDataW'(f));
      if ($urandom_range(0, 2) != 0) write_reg(CfgWidth, pick_side());
      if ($urandom_range(0, 2) != 0) write_reg(CfgHeight, pick_side());

      need = pixel_bytes(f);
      if (need == 0) begin
        nbytes = $urandom_range(1, 4);
      end else begin
        nbytes = need * $urandom_range(1, 24);
        if (need > 1 && $urandom_range(0, 7) == 0) nbytes += $urandom_range(1, need - 1);
      end

      // Long output hold while bytes keep coming back to back.
      if (phase_idx % 7 == 3 && need != 0) begin
        nbytes = need * $urandom_range(12, 24);
        steady = 1'b1;
        @(negedge clk);
        long_hold_req = 1'b1;
      end

      for (int k = 0; k < nbytes; k++) send_byte(8'($urandom_range(0, 255)));
      steady = 1'b0;
      phase_idx++;
    end

    // Let everything drain, then a few quiet cycles for stray output.
    @(negedge clk);
    s_valid = 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (EndPause) @(negedge clk);

    $display("Sent %0d bytes in used formats and %0d under unused codes; %0d pixels checked,",
             bytes_used, bytes_dropped, pixels_checked);
    $display("%0d frame ends, %0d register writes, %0d long output holds.",
             frames_closed, cfg_writes, long_holds);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ pixel_format_to_rgba8888_unit.f @@
sv/pfrgba_pkg.sv
sv/pfrgba_front.sv
sv/pfrgba_queue.sv
sv/pfrgba_back.sv
sv/pixel_format_to_rgba8888_unit.sv
tb/rgba_pixel_checker.sv
tb/pixel_format_to_rgba8888_unit_test.sv
